/* sv/btmx_pkg.sv */
`timescale 1ns / 1ps

package btmx_pkg;

  localparam int NODE_CAPACITY = 4096;
  localparam int KEY_BITS      = 30;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_CHECK,
    ST_ALLOC,
    ST_FINISH
  } state_t;

endpackage

/* sv/binary_trie_max_xor_unit.sv */
`timescale 1ns / 1ps

// Binary trie over KEY_BITS-bit keys with a maximum-XOR query.
// The input channel carries func and key. A func of insert stores the key and
// allocates missing trie nodes from a pool of NODE_CAPACITY nodes. An insert
// that needs more nodes than remain writes nothing and returns pool_full.
// A func of query returns in best_xor the largest XOR of key with any stored
// key, and trie_empty when nothing is stored yet.
// Every input transfer produces exactly one output transfer.
// One item is in work at a time. The walk reads one trie level at a time
// from the node memory (read, then evaluate), down to the last key bit for a
// query on a nonempty trie or a duplicate insert; a query on an empty trie
// ends after the first evaluate. An insert that creates new nodes passes
// through a free space check state and then writes one node per cycle. The
// next input is taken in the cycle after the result is loaded into the output
// register.
// A synchronous reset empties the trie and leaves the root as the only used
// node; no clearing pass is needed. While the receiver holds stall, the result
// stays in the output register and a finished next item waits for it to drain.
module binary_trie_max_xor_unit #(
  parameter int NODE_CAPACITY = btmx_pkg::NODE_CAPACITY,
  parameter int KEY_BITS      = btmx_pkg::KEY_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                func,
  input  logic [KEY_BITS-1:0] key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KEY_BITS-1:0] best_xor,
  output logic                trie_empty,
  output logic                pool_full
);

  localparam int PW = $clog2(NODE_CAPACITY);
  localparam int NW = $clog2(NODE_CAPACITY + 1);
  localparam int SW = NW + 1;
  localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  btmx_pkg::state_t state, state_next;

  logic [1:0][PW-1:0] mem [NODE_CAPACITY];
  logic [1:0][PW-1:0] rdata;
  logic [1:0][PW-1:0] root;
  logic [1:0][PW-1:0] cur_ent;
  logic [1:0][PW-1:0] ent;
  logic [1:0][PW-1:0] new_ent;

  logic                func_r;
  logic [KEY_BITS-1:0] key_r;
  logic [PW-1:0]       cur;
  logic [LW-1:0]       level;
  logic [KEY_BITS-1:0] best;
  logic                empty_r;
  logic                full_r;
  logic [NW-1:0]       nodes_used;

  logic          kbit;
  logic [PW-1:0] step;
  logic [PW-1:0] opp;
  logic          last;
  logic          over;
  logic          rd_en;
  logic          wr_en;
  logic          root_wr;
  logic          finish;
  logic          accept;

  assign accept = in_valid && !in_stall;
  assign kbit   = key_r[level];
  assign ent    = (cur == '0) ? root : rdata;
  assign step   = ent[kbit];
  assign opp    = ent[~kbit];
  assign last   = (level == '0);
  assign over   = (SW'(nodes_used) + SW'(level) + SW'(1)) > SW'(NODE_CAPACITY);

  always_comb begin
    new_ent       = cur_ent;
    new_ent[kbit] = nodes_used[PW-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      btmx_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = btmx_pkg::ST_READ;
        end
      end
      btmx_pkg::ST_READ: begin
        state_next = btmx_pkg::ST_EVAL;
      end
      btmx_pkg::ST_EVAL: begin
        if (func_r == btmx_pkg::FUNC_INSERT) begin
          if (step == '0) begin
            state_next = btmx_pkg::ST_CHECK;
          end else if (last) begin
            state_next = btmx_pkg::ST_FINISH;
          end else begin
            state_next = btmx_pkg::ST_READ;
          end
        end else begin
          if ((opp == '0 && step == '0) || last) begin
            state_next = btmx_pkg::ST_FINISH;
          end else begin
            state_next = btmx_pkg::ST_READ;
          end
        end
      end
      btmx_pkg::ST_CHECK: begin
        state_next = over ? btmx_pkg::ST_FINISH : btmx_pkg::ST_ALLOC;
      end
      btmx_pkg::ST_ALLOC: begin
        if (last) begin
          state_next = btmx_pkg::ST_FINISH;
        end
      end
      btmx_pkg::ST_FINISH: begin
        if (!out_valid || !out_stall) begin
          state_next = btmx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = btmx_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    root_wr  = 1'b0;
    finish   = 1'b0;
    unique case (state)
      btmx_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      btmx_pkg::ST_READ: begin
        rd_en = (cur != '0);
      end
      btmx_pkg::ST_ALLOC: begin
        wr_en   = (cur != '0);
        root_wr = (cur == '0);
      end
      btmx_pkg::ST_FINISH: begin
        finish = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= btmx_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur] <= new_ent;
    end
    if (rd_en) begin
      rdata <= mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root       <= '0;
      nodes_used <= NW'(1);
    end else if (state == btmx_pkg::ST_ALLOC) begin
      nodes_used <= nodes_used + NW'(1);
      if (root_wr) begin
        root <= new_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= func;
      key_r   <= key;
      cur     <= '0;
      level   <= LW'(KEY_BITS - 1);
      best    <= '0;
      full_r  <= 1'b0;
      empty_r <= (func == btmx_pkg::FUNC_QUERY) && (root == '0);
    end else begin
      unique case (state)
        btmx_pkg::ST_EVAL: begin
          cur_ent <= ent;
          if (func_r == btmx_pkg::FUNC_INSERT) begin
            if (step != '0) begin
              cur   <= step;
              level <= level - LW'(1);
            end
          end else if (opp != '0) begin
            best[level] <= 1'b1;
            cur         <= opp;
            level       <= level - LW'(1);
          end else if (step != '0) begin
            cur   <= step;
            level <= level - LW'(1);
          end
        end
        btmx_pkg::ST_CHECK: begin
          full_r <= over;
        end
        btmx_pkg::ST_ALLOC: begin
          cur     <= nodes_used[PW-1:0];
          cur_ent <= '0;
          level   <= level - LW'(1);
        end
        default: begin
          cur <= cur;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      best_xor   <= best;
      trie_empty <= empty_r;
      pool_full  <= full_r;
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [btmx_pkg::KEY_BITS-1:0] best_xor;
    logic                          trie_empty;
    logic                          pool_full;
  } xor_result_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_LONG,
    STALL_SHORT
  } stall_style_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          func = btmx_pkg::FUNC_INSERT;
  logic [btmx_pkg::KEY_BITS-1:0] key = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [btmx_pkg::KEY_BITS-1:0] best_xor;
  logic                          trie_empty;
  logic                          pool_full;

  int unsigned                   trie_child [0:btmx_pkg::NODE_CAPACITY-1][0:1];
  int                            nodes_used = 1;
  logic [btmx_pkg::KEY_BITS-1:0] stored_keys [$];
  xor_result_t                   expected_results [$];
  int                            fail_count = 0;
  int                            burst_left = 0;
  int                            stall_clock = 0;
  stall_style_t                  stall_style = STALL_NONE;

  binary_trie_max_xor_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .key        (key),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_xor   (best_xor),
    .trie_empty (trie_empty),
    .pool_full  (pool_full)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int trie_nodes_needed(input logic [btmx_pkg::KEY_BITS-1:0] k);
    int unsigned node;
    int          lvl;
    node = 0;
    for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
      if (trie_child[node][k[lvl]] == 0) break;
      node = trie_child[node][k[lvl]];
    end
    return lvl + 1;
  endfunction

  function automatic bit trie_insert_ok(input logic [btmx_pkg::KEY_BITS-1:0] k);
    int unsigned node;
    int          lvl;
    if (nodes_used + trie_nodes_needed(k) > btmx_pkg::NODE_CAPACITY) return 1'b0;
    node = 0;
    for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
      if (trie_child[node][k[lvl]] == 0) begin
        trie_child[nodes_used][0] = 0;
        trie_child[nodes_used][1] = 0;
        trie_child[node][k[lvl]] = nodes_used;
        nodes_used++;
      end
      node = trie_child[node][k[lvl]];
    end
    return 1'b1;
  endfunction

  function automatic logic [btmx_pkg::KEY_BITS-1:0] trie_best_xor(
    input logic [btmx_pkg::KEY_BITS-1:0] k,
    output logic                         none_stored);
    int unsigned                   node;
    int                            lvl;
    logic [btmx_pkg::KEY_BITS-1:0] best;
    node = 0;
    best = '0;
    none_stored = (trie_child[0][0] == 0) && (trie_child[0][1] == 0);
    if (none_stored) return '0;
    for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
      if (trie_child[node][~k[lvl]] != 0) begin
        best[lvl] = 1'b1;
        node = trie_child[node][~k[lvl]];
      end else if (trie_child[node][k[lvl]] != 0) begin
        node = trie_child[node][k[lvl]];
      end else begin
        break;
      end
    end
    return best;
  endfunction

  function automatic logic [btmx_pkg::KEY_BITS-1:0] pick_stored();
    if (stored_keys.size() == 0) return btmx_pkg::KEY_BITS'($urandom);
    return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
  endfunction

  // A stored key with a random number (1 to KEY_BITS) of its low bits scrambled
  // keeps the trie path of its high bits, so it needs at most that many new nodes.
  function automatic logic [btmx_pkg::KEY_BITS-1:0] near_key();
    int span;
    span = $urandom_range(1, btmx_pkg::KEY_BITS);
    return pick_stored() ^ (btmx_pkg::KEY_BITS'($urandom) &
                            ({btmx_pkg::KEY_BITS{1'b1}} >> (btmx_pkg::KEY_BITS - span)));
  endfunction

  function automatic bit find_key_needing(input int count,
                                          output logic [btmx_pkg::KEY_BITS-1:0] k);
    for (int tries = 0; tries < 4000; tries++) begin
      k = near_key();
      if (trie_nodes_needed(k) == count) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic log_failure(input string what);
    if (fail_count < 10) $display("%0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic send_op(input logic f, input logic [btmx_pkg::KEY_BITS-1:0] k);
    int          gap;
    xor_result_t want;
    logic        none_stored;
    bit          fresh_key;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    func     <= f;
    key      <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = '0;
    if (f == btmx_pkg::FUNC_INSERT) begin
      fresh_key = trie_nodes_needed(k) != 0;
      want.pool_full = !trie_insert_ok(k);
      if (fresh_key && !want.pool_full) stored_keys.push_back(k);
    end else begin
      want.best_xor = trie_best_xor(k, none_stored);
      want.trie_empty = none_stored;
    end
    expected_results.push_back(want);
  endtask

  always @(posedge clk) begin
    xor_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        log_failure($sformatf("result transfer with nothing expected: best_xor %h",
                              best_xor));
      end else begin
        want = expected_results.pop_front();
        if (best_xor !== want.best_xor || trie_empty !== want.trie_empty ||
            pool_full !== want.pool_full) begin
          log_failure($sformatf(
            "mismatch: expected best_xor %h empty %b full %b, got %h %b %b",
            want.best_xor, want.trie_empty, want.pool_full,
            best_xor, trie_empty, pool_full));
        end
      end
    end
  end

  always @(posedge clk) begin
    stall_clock <= stall_clock + 1;
    if (stall_clock % 256 == 0) stall_style <= stall_style_t'($urandom_range(0, 3));
    case (stall_style)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      STALL_LONG: begin
        out_stall <= (stall_clock % 97) < 40;
      end
      default: begin
        out_stall <= (stall_clock % 3) == 0;
      end
    endcase
  end

  task automatic test_empty_trie();
    send_op(btmx_pkg::FUNC_QUERY, '0);
    send_op(btmx_pkg::FUNC_QUERY, '1);
  endtask

  task automatic test_key_extremes();
    send_op(btmx_pkg::FUNC_INSERT, '0);
    send_op(btmx_pkg::FUNC_INSERT, '1);
    send_op(btmx_pkg::FUNC_INSERT, '0);
    send_op(btmx_pkg::FUNC_QUERY, '0);
    send_op(btmx_pkg::FUNC_QUERY, '1);
    send_op(btmx_pkg::FUNC_QUERY, 30'h2AAA_AAAA);
    send_op(btmx_pkg::FUNC_QUERY, 30'h1555_5555);
  endtask

  task automatic test_single_bits();
    send_op(btmx_pkg::FUNC_INSERT, 30'h2000_0000);
    send_op(btmx_pkg::FUNC_INSERT, 30'h0000_0001);
    send_op(btmx_pkg::FUNC_QUERY, 30'h2000_0000);
    send_op(btmx_pkg::FUNC_QUERY, 30'h0000_0001);
    send_op(btmx_pkg::FUNC_INSERT, 30'h2000_0000);
  endtask

  task automatic test_random_traffic();
    int pick;
    for (int i = 0; i < 1800; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        send_op(btmx_pkg::FUNC_QUERY, btmx_pkg::KEY_BITS'($urandom));
      end else if (pick < 30) begin
        send_op(btmx_pkg::FUNC_QUERY, pick_stored());
      end else if (pick < 40) begin
        send_op(btmx_pkg::FUNC_QUERY, ~pick_stored());
      end else if (pick < 75) begin
        send_op(btmx_pkg::FUNC_INSERT, btmx_pkg::KEY_BITS'($urandom));
      end else if (pick < 90) begin
        send_op(btmx_pkg::FUNC_INSERT, near_key());
      end else begin
        send_op(btmx_pkg::FUNC_INSERT, pick_stored());
      end
    end
  endtask

  task automatic test_pool_boundary();
    int                            spare;
    logic [btmx_pkg::KEY_BITS-1:0] k;
    while (nodes_used + btmx_pkg::KEY_BITS <= btmx_pkg::NODE_CAPACITY) begin
      send_op(btmx_pkg::FUNC_INSERT, btmx_pkg::KEY_BITS'($urandom));
    end
    spare = btmx_pkg::NODE_CAPACITY - nodes_used;
    if (spare > 0 && find_key_needing(spare + 1, k)) send_op(btmx_pkg::FUNC_INSERT, k);
    if (spare > 0 && find_key_needing(spare, k)) send_op(btmx_pkg::FUNC_INSERT, k);
    if (find_key_needing(1, k)) send_op(btmx_pkg::FUNC_INSERT, k);
    send_op(btmx_pkg::FUNC_INSERT, pick_stored());
    send_op(btmx_pkg::FUNC_QUERY, btmx_pkg::KEY_BITS'($urandom));
    send_op(btmx_pkg::FUNC_QUERY, ~pick_stored());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_trie();
    test_key_extremes();
    test_single_bits();
    test_random_traffic();
    test_pool_boundary();
    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * btmx_pkg::KEY_BITS + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
